/* hw/rtl/jhr_pkg.sv */
// ----------------------------------------------------------------------------
// jhr_pkg
// Shared constants and codes of the heat-plate relaxation block.
// ----------------------------------------------------------------------------
`default_nettype none

package jhr_pkg;

	localparam int CELL_W = 23;
	localparam int IDX_W  = 8;
	localparam int CNT_W  = 16;
	localparam int REG_W  = 2;

	localparam int DEFAULT_GRID_WIDTH  = 16;
	localparam int DEFAULT_GRID_HEIGHT = 16;

	localparam int HOT_LO = 7;
	localparam int HOT_HI = 8;

	localparam logic [CELL_W-1:0] THRESHOLD_RST    = 23'd655;
	localparam logic [CELL_W-1:0] HOT_TEMP_RST     = 23'd6553600;
	localparam logic [CELL_W-1:0] CORNER_TEMP_RST  = 23'd0;
	localparam logic [CELL_W-1:0] INITIAL_TEMP_RST = 23'd3276800;

	// floor(x / 3) == (x * DIV3_MUL) >> DIV3_SHIFT for every x below 2**25
	localparam int                SUM_W      = CELL_W + 2;
	localparam int                DIV3_SHIFT = 26;
	localparam logic [SUM_W-1:0]  DIV3_MUL   = 25'd22369622;

	localparam logic [1:0] OP_INIT  = 2'd0;
	localparam logic [1:0] OP_SWEEP = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [REG_W-1:0] REG_THRESHOLD    = 2'd0;
	localparam logic [REG_W-1:0] REG_HOT_TEMP     = 2'd1;
	localparam logic [REG_W-1:0] REG_CORNER_TEMP  = 2'd2;
	localparam logic [REG_W-1:0] REG_INITIAL_TEMP = 2'd3;

endpackage

`default_nettype wire

/* hw/rtl/jacobi_hotplate_relaxation_top.sv */
// ----------------------------------------------------------------------------
// jacobi_hotplate_relaxation_top
// Jacobi relaxation of a heat plate held in two ping-pong grid memories.
// ----------------------------------------------------------------------------
// Command channel: a word (operation, cell_index) is taken at a clock edge with
// start high and busy low. Each command gives one result word on value,
// converged and sweep_count, shown for one cycle while done is high; the
// receiver cannot hold it off.
// Configuration: cfg_we writes cfg_data to register cfg_index at once; write
// only while busy is low and no result is pending.
// Work per command, from the accepting edge to the done cycle:
//   initialize  one cell written per cycle
//   sweep       one grid read per cycle streams through a 2*GRID_WIDTH shift
//               line, a three-stage average pipeline writes the other memory
//   read        the registered memory read
//   no-op code  a zero result word; busy stays low
// One command is in work at a time; else busy stays high until its result.
// Reset loads the register defaults and clears the sweep count and the last
// change; the grid memories hold nothing defined until the first initialize.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_hotplate_relaxation_top
	import jhr_pkg::*;
#(
	parameter int GRID_WIDTH  = DEFAULT_GRID_WIDTH,
	parameter int GRID_HEIGHT = DEFAULT_GRID_HEIGHT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        operation,
	input  wire logic [IDX_W-1:0]  cell_index,
	output logic                   done,
	output logic      [CELL_W-1:0] value,
	output logic                   converged,
	output logic      [CNT_W-1:0]  sweep_count,
	input  wire logic              cfg_we,
	input  wire logic [REG_W-1:0]  cfg_index,
	input  wire logic [CELL_W-1:0] cfg_data
);

	localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + GRID_WIDTH + 1);
	localparam int RW    = $clog2(GRID_HEIGHT);
	localparam int CLW   = $clog2(GRID_WIDTH);
	localparam int XW    = ((AW > IDX_W) ? AW : IDX_W) + 1;
	localparam int PW    = 2 * SUM_W;
	localparam int SHL   = 2 * GRID_WIDTH;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_INIT   = 5'b00010,
		ST_SWEEP  = 5'b00100,
		ST_FINISH = 5'b01000,
		ST_READ   = 5'b10000
	} state_t;

	state_t            state_q;
	logic              cur_q;
	logic [CW-1:0]     iss_q;
	logic              dv_q;
	logic              kok_q;
	logic              klast_q;
	logic [RW-1:0]     row_q;
	logic [CLW-1:0]    col_q;
	logic [AW-1:0]     cen_q;
	logic              range_q;
	logic              done_q;
	logic [CELL_W-1:0] value_q;
	logic [CELL_W-1:0] max_q;
	logic [CELL_W-1:0] last_change_q;
	logic [CNT_W-1:0]  sweeps_q;
	logic [CELL_W-1:0] threshold_q;
	logic [CELL_W-1:0] hot_temp_q;
	logic [CELL_W-1:0] corner_temp_q;
	logic [CELL_W-1:0] initial_temp_q;

	logic [CELL_W-1:0] sh_q [SHL];

	logic              v_s1, v_s2, v_s3;
	logic              last_s1, last_s2, last_s3;
	logic [AW-1:0]     addr_s1, addr_s2, addr_s3;
	logic [CELL_W-1:0] old_s1, old_s2;
	logic              fixed_s1, fixed_s2;
	logic [SUM_W-1:0]  sum_s1, sum_s2;
	logic [2:0]        n_s1, n_s2;
	logic [PW-1:0]     prod_s2;
	logic [CELL_W-1:0] avg_s3, diff_s3;

	logic [XW-1:0]     idx_x;
	logic              in_range;
	logic [AW-1:0]     read_addr;
	logic [AW-1:0]     raddr;
	logic [AW-1:0]     waddr;
	logic [CELL_W-1:0] wdata;
	logic              we_a, we_b;
	logic [CELL_W-1:0] rdata_a, rdata_b, rdata_cur;
	logic              is_corner, is_hot, fixed_cell;
	logic              col_last, row_last;
	logic              has_l, has_r, has_u, has_d;
	logic [SUM_W-1:0]  win_sum;
	logic [2:0]        win_n;
	logic [CELL_W-1:0] init_val;
	logic              win_take;
	logic [CW-1:0]     iss_end;
	logic [CELL_W-1:0] quot;
	logic [CELL_W-1:0] avg_c;
	logic              init_we;

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign value       = value_q;
	assign converged   = (sweeps_q != '0) && (last_change_q <= threshold_q);
	assign sweep_count = sweeps_q;

	assign idx_x     = XW'(cell_index);
	assign in_range  = idx_x < XW'(CELLS);
	assign read_addr = in_range ? idx_x[AW-1:0] : '0;
	assign iss_end   = CW'(CELLS + GRID_WIDTH);

	assign is_corner  = ((row_q == '0) || (row_q == RW'(GRID_HEIGHT - 1)))
		&& ((col_q == '0) || (col_q == CLW'(GRID_WIDTH - 1)));
	assign is_hot     = ((row_q == RW'(HOT_LO)) || (row_q == RW'(HOT_HI)))
		&& ((col_q == CLW'(HOT_LO)) || (col_q == CLW'(HOT_HI)));
	assign fixed_cell = is_corner || is_hot;
	assign col_last   = (col_q == CLW'(GRID_WIDTH - 1));
	assign row_last   = (row_q == RW'(GRID_HEIGHT - 1));

	assign init_val = is_corner ? corner_temp_q : (is_hot ? hot_temp_q : initial_temp_q);

	assign has_l = (col_q != '0);
	assign has_r = !col_last;
	assign has_u = (row_q != '0);
	assign has_d = !row_last;

	// window around the center cell: down is the word now leaving the memory
	assign win_sum = (has_l ? SUM_W'(sh_q[GRID_WIDTH])     : '0)
		+ (has_r ? SUM_W'(sh_q[GRID_WIDTH - 2]) : '0)
		+ (has_u ? SUM_W'(sh_q[SHL - 1])        : '0)
		+ (has_d ? SUM_W'(rdata_cur)            : '0);
	assign win_n   = {2'b00, has_l} + {2'b00, has_r} + {2'b00, has_u} + {2'b00, has_d};

	assign win_take = (state_q == ST_SWEEP) && dv_q && kok_q;
	assign init_we  = (state_q == ST_INIT);

	assign raddr = (state_q == ST_SWEEP)
		? ((iss_q < CW'(CELLS)) ? iss_q[AW-1:0] : '0)
		: read_addr;
	assign waddr = init_we ? iss_q[AW-1:0] : addr_s3;
	assign wdata = init_we ? init_val : avg_s3;
	assign we_a  = (init_we && !cur_q) || (v_s3 && cur_q);
	assign we_b  = (init_we && cur_q) || (v_s3 && !cur_q);

	assign rdata_cur = cur_q ? rdata_b : rdata_a;

	always_comb begin
		case (n_s2)
			3'd4:    quot = sum_s2[2 +: CELL_W];
			3'd2:    quot = sum_s2[1 +: CELL_W];
			default: quot = prod_s2[DIV3_SHIFT +: CELL_W];
		endcase
		avg_c = fixed_s2 ? old_s2 : quot;
	end

	jhr_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_bank_a (
		.clk  (clk),
		.we   (we_a),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_a)
	);

	jhr_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_bank_b (
		.clk  (clk),
		.we   (we_b),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= THRESHOLD_RST;
			hot_temp_q     <= HOT_TEMP_RST;
			corner_temp_q  <= CORNER_TEMP_RST;
			initial_temp_q <= INITIAL_TEMP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD:    threshold_q    <= cfg_data;
				REG_HOT_TEMP:     hot_temp_q     <= cfg_data;
				REG_CORNER_TEMP:  corner_temp_q  <= cfg_data;
				REG_INITIAL_TEMP: initial_temp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cur_q         <= 1'b0;
			iss_q         <= '0;
			dv_q          <= 1'b0;
			kok_q         <= 1'b0;
			klast_q       <= 1'b0;
			row_q         <= '0;
			col_q         <= '0;
			cen_q         <= '0;
			range_q       <= 1'b0;
			done_q        <= 1'b0;
			value_q       <= '0;
			max_q         <= '0;
			last_change_q <= '0;
			sweeps_q      <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			last_s1       <= 1'b0;
			last_s2       <= 1'b0;
			last_s3       <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			v_s1    <= win_take;
			last_s1 <= klast_q;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			v_s3    <= v_s2;
			last_s3 <= last_s2;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						iss_q <= '0;
						row_q <= '0;
						col_q <= '0;
						cen_q <= '0;
						unique case (operation)
							OP_INIT:  state_q <= ST_INIT;
							OP_SWEEP: begin
								state_q <= ST_SWEEP;
								max_q   <= '0;
							end
							OP_READ: begin
								state_q <= ST_READ;
								range_q <= in_range;
							end
							OP_NOP: begin
								done_q  <= 1'b1;
								value_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_INIT: begin
					iss_q <= iss_q + 1'b1;
					col_q <= col_last ? '0 : col_q + 1'b1;
					if (col_last) begin
						row_q <= row_q + 1'b1;
					end
					if (iss_q == CW'(CELLS - 1)) begin
						state_q       <= ST_IDLE;
						done_q        <= 1'b1;
						value_q       <= '0;
						last_change_q <= '0;
						sweeps_q      <= '0;
					end
				end
				ST_SWEEP: begin
					dv_q    <= (iss_q != iss_end);
					kok_q   <= (iss_q >= CW'(GRID_WIDTH));
					klast_q <= (iss_q == iss_end - 1'b1);
					if (iss_q != iss_end) begin
						iss_q <= iss_q + 1'b1;
					end
					if (win_take) begin
						cen_q <= cen_q + 1'b1;
						col_q <= col_last ? '0 : col_q + 1'b1;
						if (col_last) begin
							row_q <= row_q + 1'b1;
						end
					end
					if (v_s3) begin
						if (diff_s3 > max_q) begin
							max_q <= diff_s3;
						end
						if (last_s3) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					state_q       <= ST_IDLE;
					cur_q         <= !cur_q;
					last_change_q <= max_q;
					if (sweeps_q != '1) begin
						sweeps_q <= sweeps_q + 1'b1;
					end
					done_q        <= 1'b1;
					value_q       <= max_q;
				end
				ST_READ: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					value_q <= range_q ? rdata_cur : '0;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (dv_q) begin
			sh_q[0] <= rdata_cur;
			for (int m = 1; m < SHL; m++) begin
				sh_q[m] <= sh_q[m-1];
			end
		end
		addr_s1  <= cen_q;
		old_s1   <= sh_q[GRID_WIDTH - 1];
		fixed_s1 <= fixed_cell;
		sum_s1   <= win_sum;
		n_s1     <= win_n;

		addr_s2  <= addr_s1;
		old_s2   <= old_s1;
		fixed_s2 <= fixed_s1;
		sum_s2   <= sum_s1;
		n_s2     <= n_s1;
		prod_s2  <= PW'(sum_s1) * PW'(DIV3_MUL);

		addr_s3  <= addr_s2;
		avg_s3   <= avg_c;
		diff_s3  <= (avg_c >= old_s2) ? (avg_c - old_s2) : (old_s2 - avg_c);
	end

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == ST_IDLE))
		else $error("result strobe outside idle");

	a_one_bank_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(we_a && we_b))
		else $error("both grid memories written in one cycle");

	a_s3_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (state_q == ST_SWEEP))
		else $error("average pipeline active outside a sweep");

	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |=> (cur_q != $past(cur_q)) && done_q)
		else $error("sweep finish did not swap grids");
`endif

endmodule

`default_nettype wire

/* hw/rtl/jhr_ram.sv */
// ----------------------------------------------------------------------------
// jhr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module jhr_ram #(
	parameter  int WIDTH = 23,
	parameter  int DEPTH = 256,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
